>>> rtl/core/index_to_colour_mapper_macros.svh
// assertion macros for the index to colour mapper
// used by index_to_colour_mapper.sv; expects i_clk and i_rst_n in scope
`ifndef INDEX_TO_COLOUR_MAPPER_MACROS_SVH
`define INDEX_TO_COLOUR_MAPPER_MACROS_SVH

// implication in the same cycle
`define ITCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itcm check failed");

// implication in the next cycle
`define ITCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itcm check failed");

`endif

>>> rtl/core/itcm_pkg.sv
// shared types and constants for the index to colour mapper
// no dependencies
`timescale 1ns / 1ps

package itcm_pkg;

    localparam int IDX_W     = 16;
    localparam int CFG_W     = 16;
    localparam int ADDR_W    = 3;
    localparam int DIV_W     = 32;
    localparam int DVS_W     = 24;
    localparam int REM_W     = DVS_W + 1;
    localparam int SIX_W     = IDX_W + 3;
    localparam int T_W       = IDX_W + 1;

    localparam logic MODE_GREY = 1'b0;
    localparam logic MODE_HUE  = 1'b1;

    typedef enum logic [ADDR_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_GREY   = 3'd2,
        CFG_PERIOD = 3'd3,
        CFG_SAT    = 3'd4,
        CFG_BRIGHT = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dq;
        logic [DVS_W-1:0] dvs;
    } t_div;

    typedef struct packed {
        logic       mode;
        logic       black;
        logic       oor;
        logic [7:0] grey;
        t_sector    sector;
    } t_side;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       oor;
    } t_pix;

endpackage

>>> rtl/core/itcm_div_cell.sv
// one restoring division step, registered
// depends on itcm_pkg
`timescale 1ns / 1ps

module itcm_div_cell
    import itcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_div  i_div,
    input  t_side i_side,
    output logic  o_valid,
    output t_div  o_div,
    output t_side o_side
);

    logic          r_valid;
    t_div          r_div;
    t_side         r_side;
    t_div          n_div;
    logic [REM_W-1:0] w_sh;

    always_comb begin
        w_sh  = {i_div.rem[REM_W-2:0], i_div.dq[DIV_W-1]};
        n_div = i_div;
        if (w_sh >= {1'b0, i_div.dvs}) begin
            n_div.rem = w_sh - {1'b0, i_div.dvs};
            n_div.dq  = {i_div.dq[DIV_W-2:0], 1'b1};
        end else begin
            n_div.rem = w_sh;
            n_div.dq  = {i_div.dq[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

>>> rtl/core/itcm_div_chain.sv
// row of division cells, one quotient bit per cell
// depends on itcm_pkg and itcm_div_cell
`timescale 1ns / 1ps

module itcm_div_chain
    import itcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_div  i_div,
    input  t_side i_side,
    output logic  o_valid,
    output t_div  o_div,
    output t_side o_side
);

    logic  w_valid [DIV_W+1];
    t_div  w_div   [DIV_W+1];
    t_side w_side  [DIV_W+1];

    assign w_valid[0] = i_valid;
    assign w_div[0]   = i_div;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < DIV_W; g++) begin : g_cell
        itcm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_div   (w_div[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[DIV_W];
    assign o_div   = w_div[DIV_W];
    assign o_side  = w_side[DIV_W];

endmodule

>>> rtl/core/itcm_out_queue.sv
// two entry output queue, registered output
// depends on itcm_pkg
`timescale 1ns / 1ps

module itcm_out_queue
    import itcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_pix,
    output logic o_full,
    output logic o_valid,
    input  logic i_ready,
    output t_pix o_pix
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_pix       r_q [2];
    logic       w_pop;
    logic [1:0] w_wr;

    assign w_pop = (r_cnt != 2'd0) && i_ready;
    assign w_wr  = r_cnt - {1'b0, w_pop};

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (w_wr[0] == 1'b0)) begin
            r_q[0] <= i_pix;
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && w_wr[0]) begin
            r_q[1] <= i_pix;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pix   = r_q[0];

endmodule

>>> rtl/core/index_to_colour_mapper.sv
// index to rgba colour mapper, grey ramp or hsv hue wheel
// depends on itcm_pkg, itcm_div_chain, itcm_out_queue, index_to_colour_mapper_macros.svh
//
//  channel | signals                               | dir
//  in      | i_in_valid o_in_ready i_level_index   | beat in
//  out     | o_out_valid i_out_ready o_red..o_alpha | beat out
//  cfg     | i_cfg_we i_cfg_addr i_cfg_wdata        | write only
//
// one beat per cycle while the output queue is not full; two 32-cell divider rows
// the divider rows and the hue stages advance together; a two entry output
// queue holds results, and input stalls only when that queue is full
// synchronous active low reset clears valids and config to defaults
`timescale 1ns / 1ps
`include "index_to_colour_mapper_macros.svh"

module index_to_colour_mapper
    import itcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [IDX_W-1:0]  i_level_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha,
    output logic              o_out_of_range,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    // configuration
    logic             r_mode;
    logic [IDX_W-1:0] r_top;
    logic [7:0]       r_gcyc;
    logic [IDX_W-1:0] r_per;
    logic [7:0]       r_sat;
    logic [7:0]       r_bri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HUE;
            r_top  <= 16'd256;
            r_gcyc <= 8'd1;
            r_per  <= 16'd256;
            r_sat  <= 8'd255;
            r_bri  <= 8'd255;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_MODE:   r_mode <= i_cfg_wdata[0];
                CFG_TOP:    r_top  <= i_cfg_wdata;
                CFG_GREY:   r_gcyc <= i_cfg_wdata[7:0];
                CFG_PERIOD: r_per  <= i_cfg_wdata;
                CFG_SAT:    r_sat  <= i_cfg_wdata[7:0];
                CFG_BRIGHT: r_bri  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // values derived from configuration
    logic [IDX_W-1:0] r_peff;
    logic [SIX_W-1:0] r_p1, r_p2, r_p3, r_p4, r_p5;
    logic [15:0]      r_vs, r_vns;
    logic [7:0]       r_lo;
    logic [DVS_W-1:0] r_dm;
    logic [IDX_W-1:0] w_peff;
    logic [7:0]       w_nsat;
    logic [15:0]      w_vns;
    logic [16:0]      w_lo_sum;

    assign w_peff   = (r_per == '0) ? IDX_W'(1) : r_per;
    assign w_nsat   = 8'd255 - r_sat;
    assign w_vns    = r_bri * w_nsat;
    assign w_lo_sum = {1'b0, w_vns} + 17'(w_vns[15:8]) + 17'd1;

    always_ff @(posedge i_clk) begin
        r_peff <= w_peff;
        r_p1   <= SIX_W'(w_peff);
        r_p2   <= SIX_W'({w_peff, 1'b0});
        r_p3   <= SIX_W'({w_peff, 1'b0}) + SIX_W'(w_peff);
        r_p4   <= SIX_W'({w_peff, 2'b0});
        r_p5   <= SIX_W'({w_peff, 2'b0}) + SIX_W'(w_peff);
        r_vs   <= r_bri * r_sat;
        r_vns  <= w_vns;
        r_lo   <= w_lo_sum[15:8];
        r_dm   <= DVS_W'({w_peff, 8'b0}) - DVS_W'(w_peff);
    end

    // global advance
    logic w_full;
    logic w_en;

    assign w_en       = !w_full;
    assign o_in_ready = w_en;

    // input stage
    logic             r_v0;
    logic [IDX_W-1:0] r_idx0;
    t_side            r_sd0;

    // grey product stage
    logic             r_v1;
    logic [IDX_W-1:0] r_idx1;
    logic [23:0]      r_m1;
    t_side            r_sd1;

    // divider input stage
    logic             r_v2;
    t_div             r_d2;
    t_side            r_sd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx0       <= i_level_index;
            r_sd0.mode   <= r_mode;
            r_sd0.black  <= (i_level_index >= r_top);
            r_sd0.oor    <= (i_level_index > r_top);
            r_sd0.grey   <= 8'd0;
            r_sd0.sector <= SEC_0;

            r_idx1 <= r_idx0;
            r_m1   <= r_idx0 * r_gcyc;
            r_sd1  <= r_sd0;

            r_sd2     <= r_sd1;
            r_d2.rem  <= '0;
            if (r_sd1.mode == MODE_HUE) begin
                r_d2.dq  <= DIV_W'(r_idx1);
                r_d2.dvs <= DVS_W'(r_peff);
            end else begin
                r_d2.dq  <= {r_m1, 8'b0} - DIV_W'(r_m1);
                r_d2.dvs <= DVS_W'(r_top);
            end
        end
    end

    // first divider row: grey quotient or hue remainder
    logic  w_va;
    t_div  w_da;
    t_side w_sa;

    itcm_div_chain u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_div   (r_d2),
        .i_side  (r_sd2),
        .o_valid (w_va),
        .o_div   (w_da),
        .o_side  (w_sa)
    );

    // hue stages
    logic             r_vh1, r_vh2, r_vh3, r_vh4, r_vh5;
    t_side            r_sh1, r_sh2, r_sh3, r_sh4;
    logic [SIX_W-1:0] r_six;
    logic [T_W-1:0]   r_t;
    logic [IDX_W-1:0] r_a;
    logic [31:0]      r_t1, r_t2;
    t_div             r_d5;
    t_side            r_sh5;
    t_sector          w_sec;
    logic [SIX_W-1:0] w_base;
    logic [T_W-1:0]   w_dist;
    t_side            w_sh1;
    t_side            w_sh2;

    always_comb begin
        w_sh1      = w_sa;
        w_sh1.grey = w_da.dq[7:0];
    end

    always_comb begin
        if (r_six >= r_p5) begin
            w_sec = SEC_5;
        end else if (r_six >= r_p4) begin
            w_sec = SEC_4;
        end else if (r_six >= r_p3) begin
            w_sec = SEC_3;
        end else if (r_six >= r_p2) begin
            w_sec = SEC_2;
        end else if (r_six >= r_p1) begin
            w_sec = SEC_1;
        end else begin
            w_sec = SEC_0;
        end
        if (r_six >= r_p4) begin
            w_base = r_p4;
        end else if (r_six >= r_p2) begin
            w_base = r_p2;
        end else begin
            w_base = '0;
        end
    end

    always_comb begin
        w_sh2        = r_sh1;
        w_sh2.sector = w_sec;
    end

    assign w_dist = (r_t >= T_W'(r_peff)) ? (r_t - T_W'(r_peff)) : (T_W'(r_peff) - r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh1 <= 1'b0;
            r_vh2 <= 1'b0;
            r_vh3 <= 1'b0;
            r_vh4 <= 1'b0;
            r_vh5 <= 1'b0;
        end else if (w_en) begin
            r_vh1 <= w_va;
            r_vh2 <= r_vh1;
            r_vh3 <= r_vh2;
            r_vh4 <= r_vh3;
            r_vh5 <= r_vh4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sh1 <= w_sh1;
            r_six <= SIX_W'({w_da.rem[IDX_W-1:0], 2'b0}) + SIX_W'({w_da.rem[IDX_W-1:0], 1'b0});

            r_sh2 <= w_sh2;
            r_t   <= T_W'(r_six - w_base);

            r_sh3 <= r_sh2;
            r_a   <= IDX_W'(T_W'(r_peff) - w_dist);

            r_sh4 <= r_sh3;
            r_t1  <= r_vs * r_a;
            r_t2  <= r_vns * r_peff;

            r_sh5     <= r_sh4;
            r_d5.rem  <= '0;
            r_d5.dq   <= r_t1 + r_t2;
            r_d5.dvs  <= r_dm;
        end
    end

    // second divider row: mid level
    logic  w_vb;
    t_div  w_db;
    t_side w_sb;

    itcm_div_chain u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vh5),
        .i_div   (r_d5),
        .i_side  (r_sh5),
        .o_valid (w_vb),
        .o_div   (w_db),
        .o_side  (w_sb)
    );

    // colour assembly
    t_pix       w_pix;
    logic [7:0] w_mid;

    assign w_mid = w_db.dq[7:0];

    always_comb begin
        w_pix.oor = w_sb.oor;
        if (w_sb.black) begin
            w_pix.red   = 8'd0;
            w_pix.green = 8'd0;
            w_pix.blue  = 8'd0;
        end else if (w_sb.mode == MODE_GREY) begin
            w_pix.red   = w_sb.grey;
            w_pix.green = w_sb.grey;
            w_pix.blue  = w_sb.grey;
        end else begin
            case (w_sb.sector)
                SEC_0: begin
                    w_pix.red = r_bri; w_pix.green = w_mid; w_pix.blue = r_lo;
                end
                SEC_1: begin
                    w_pix.red = w_mid; w_pix.green = r_bri; w_pix.blue = r_lo;
                end
                SEC_2: begin
                    w_pix.red = r_lo; w_pix.green = r_bri; w_pix.blue = w_mid;
                end
                SEC_3: begin
                    w_pix.red = r_lo; w_pix.green = w_mid; w_pix.blue = r_bri;
                end
                SEC_4: begin
                    w_pix.red = w_mid; w_pix.green = r_lo; w_pix.blue = r_bri;
                end
                default: begin
                    w_pix.red = r_bri; w_pix.green = r_lo; w_pix.blue = w_mid;
                end
            endcase
        end
    end

    t_pix w_opix;

    itcm_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_vb),
        .i_pix   (w_pix),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pix   (w_opix)
    );

    assign o_red          = w_opix.red;
    assign o_green        = w_opix.green;
    assign o_blue         = w_opix.blue;
    assign o_alpha        = 8'hff;
    assign o_out_of_range = w_opix.oor;

    // checks
    `ITCM_ASSERT_NOW(a_oor_black, o_out_valid && o_out_of_range, {o_red, o_green, o_blue} == 24'd0)
    `ITCM_ASSERT_NEXT(a_full_stalls, w_full && !i_out_ready, !o_in_ready)
    `ITCM_ASSERT_NEXT(a_push_shows, w_en && w_vb, o_out_valid)

endmodule

>>> sim/index_to_colour_mapper_checker.sv
// checker for index_to_colour_mapper: follows config writes, predicts each beat
// and compares the output stream in order; depends on itcm_pkg
`timescale 1ns / 1ps

module index_to_colour_mapper_checker
    import itcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [IDX_W-1:0]  i_level_index,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_alpha,
    input  logic              i_out_of_range,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [7:0] OPAQUE = 8'hff;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       oor;
    } t_colour;

    logic             mode;
    logic [IDX_W-1:0] top;
    logic [7:0]       cycles;
    logic [IDX_W-1:0] period;
    logic [7:0]       sat;
    logic [7:0]       bright;
    t_colour          colour_q[$];

    initial o_fail_count = 0;
    assign o_pending = colour_q.size();

    function automatic t_colour map_index(logic [IDX_W-1:0] idx);
        t_colour     c;
        longint unsigned p, r, six, t, span, a, v, s, lo, mid, g;
        t_sector     sec;
        c.red = 8'd0;
        c.green = 8'd0;
        c.blue = 8'd0;
        c.alpha = OPAQUE;
        c.oor = idx > top;
        if (idx < top) begin
            if (mode == MODE_GREY) begin
                g = (longint'(idx) * cycles * 255) / top;
                c.red = g[7:0];
                c.green = g[7:0];
                c.blue = g[7:0];
            end else begin
                p = (period == 0) ? 1 : period;
                r = idx % p;
                six = 6 * r;
                sec = t_sector'(six / p);
                t = six % (2 * p);
                span = (t >= p) ? t - p : p - t;
                a = p - span;
                v = bright;
                s = sat;
                lo = (v * (255 - s)) / 255;
                mid = (v * s * a + v * (255 - s) * p) / (255 * p);
                case (sec)
                    SEC_0: begin c.red = 8'(v); c.green = 8'(mid); c.blue = 8'(lo); end
                    SEC_1: begin c.red = 8'(mid); c.green = 8'(v); c.blue = 8'(lo); end
                    SEC_2: begin c.red = 8'(lo); c.green = 8'(v); c.blue = 8'(mid); end
                    SEC_3: begin c.red = 8'(lo); c.green = 8'(mid); c.blue = 8'(v); end
                    SEC_4: begin c.red = 8'(mid); c.green = 8'(lo); c.blue = 8'(v); end
                    default: begin c.red = 8'(v); c.green = 8'(lo); c.blue = 8'(mid); end
                endcase
            end
        end
        return c;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_colour want;
        if (!i_rst_n) begin
            mode <= MODE_HUE;
            top <= 16'd256;
            cycles <= 8'd1;
            period <= 16'd256;
            sat <= 8'd255;
            bright <= 8'd255;
            colour_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_MODE:   mode <= i_cfg_wdata[0];
                    CFG_TOP:    top <= i_cfg_wdata[IDX_W-1:0];
                    CFG_GREY:   cycles <= i_cfg_wdata[7:0];
                    CFG_PERIOD: period <= i_cfg_wdata[IDX_W-1:0];
                    CFG_SAT:    sat <= i_cfg_wdata[7:0];
                    CFG_BRIGHT: bright <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (colour_q.size() == 0) begin
                    report("unexpected beat", i_red, 0);
                end else begin
                    want = colour_q.pop_front();
                    if (i_red !== want.red) report("red", i_red, want.red);
                    if (i_green !== want.green) report("green", i_green, want.green);
                    if (i_blue !== want.blue) report("blue", i_blue, want.blue);
                    if (i_alpha !== want.alpha) report("alpha", i_alpha, want.alpha);
                    if (i_out_of_range !== want.oor)
                        report("out_of_range", i_out_of_range, want.oor);
                end
            end
            if (i_in_valid && i_in_ready) colour_q.push_back(map_index(i_level_index));
        end
    end

endmodule

>>> sim/index_to_colour_mapper_tb.sv
// testbench top for index_to_colour_mapper: clock, reset, stimulus and verdict
// depends on itcm_pkg, index_to_colour_mapper and index_to_colour_mapper_checker
`timescale 1ns / 1ps

module index_to_colour_mapper_tb;
    import itcm_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [IDX_W-1:0]  level_index = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        red, green, blue, alpha;
    logic              out_of_range;
    logic              cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    int                fail_count;
    int                pending;
    bit                no_idle = 1'b0;
    bit                hold_req = 1'b0;
    int                top_now = 256;

    always #2 i_clk = ~i_clk;

    index_to_colour_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_level_index(level_index),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_red(red), .o_green(green), .o_blue(blue), .o_alpha(alpha),
        .o_out_of_range(out_of_range),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    index_to_colour_mapper_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_level_index(level_index),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_red(red), .i_green(green), .i_blue(blue), .i_alpha(alpha),
        .i_out_of_range(out_of_range),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // output side stalls
    initial begin
        bit held;
        int n;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            n = no_idle ? 0 : $urandom_range(0, 12);
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_index(logic [IDX_W-1:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        level_index <= idx;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (r == CFG_TOP) top_now = int'(val);
    endtask

    task automatic set_all(logic m, int top, int cyc, int per, int s, int v);
        write_reg(CFG_MODE, CFG_W'(m));
        write_reg(CFG_TOP, CFG_W'(top));
        write_reg(CFG_GREY, CFG_W'(cyc));
        write_reg(CFG_PERIOD, CFG_W'(per));
        write_reg(CFG_SAT, CFG_W'(s));
        write_reg(CFG_BRIGHT, CFG_W'(v));
    endtask

    task automatic send_random(int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) send_index(IDX_W'($urandom));
            else send_index(IDX_W'($urandom_range(0,
                            top_now + 2 > 65535 ? 65535 : top_now + 2)));
        end
    endtask

    initial begin
        int k;
        logic [IDX_W-1:0] corners [12];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: hue wheel, every sector edge, top and beyond
        corners = '{16'd0, 16'd1, 16'd42, 16'd43, 16'd85, 16'd128, 16'd171, 16'd213,
                    16'd255, 16'd256, 16'd257, 16'hffff};
        foreach (corners[j])
            send_index(corners[j]);
        wait_drained();

        set_all(MODE_GREY, 16'hffff, 8'd255, 16'hffff, 8'd0, 8'd0);
        send_index(16'd0);
        send_index(16'h8000);
        send_index(16'hfffe);
        send_index(16'hffff);
        send_random(20);
        wait_drained();

        // zero top, zero period, zero cycles
        set_all(MODE_HUE, 16'd0, 8'd0, 16'd0, 8'd128, 8'd200);
        send_index(16'd0);
        send_index(16'd1);
        wait_drained();
        write_reg(CFG_TOP, 16'd1000);
        send_index(16'd7);
        send_index(16'd999);
        wait_drained();
        write_reg(CFG_MODE, CFG_W'(MODE_GREY));
        send_index(16'd7);
        wait_drained();

        // back to back with a long output stall
        set_all(MODE_HUE, 16'hffff, 8'd3, 16'hffff, 8'd255, 8'd255);
        no_idle = 1'b1;
        hold_req = 1'b1;
        send_random(120);
        no_idle = 1'b0;
        wait_drained();

        for (k = 0; k < 10; k++) begin
            set_all(1'($urandom_range(0, 1)), $urandom_range(1, 4) == 1 ? 16'd1 :
                    $urandom_range(0, 65535), $urandom_range(0, 255),
                    $urandom_range(0, 3) == 0 ? 16'd1 : $urandom_range(0, 65535),
                    $urandom_range(0, 255), $urandom_range(0, 255));
            send_random(24);
            wait_drained();
        end

        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> index_to_colour_mapper.f
+incdir+rtl/core
rtl/core/itcm_pkg.sv
rtl/core/itcm_div_cell.sv
rtl/core/itcm_div_chain.sv
rtl/core/itcm_out_queue.sv
rtl/core/index_to_colour_mapper.sv
sim/index_to_colour_mapper_checker.sv
sim/index_to_colour_mapper_tb.sv
